>>> src/gfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GNSS frame classifier package
// Shared types and constants for the frame classifier.
// ----------------------------------------------------------------------------
package gfc_pkg;

  localparam logic [7:0] StartText = 8'h24;
  localparam logic [7:0] StartBin  = 8'hB5;
  localparam logic [7:0] SyncTwo   = 8'h62;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ClassAck  = 8'h05;
  localparam logic [7:0] ClassTp   = 8'h0D;
  localparam logic [7:0] IdAck     = 8'h01;

  localparam int unsigned MaxWidth    = 10;
  localparam logic [MaxWidth-1:0] MaxDefault = 10'd500;

  localparam logic [2:0] RegNmeaMax = 3'd0;

  typedef enum logic [2:0] {
    KIND_NMEA     = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_NAK      = 3'd2,
    KIND_TP       = 3'd3,
    KIND_UNKNOWN  = 3'd4,
    KIND_TOO_LONG = 3'd5,
    KIND_BAD_SYNC = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [16:0] frame_bytes;
  } result_t;

endpackage
`default_nettype wire

>>> src/gfc_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GNSS frame classifier byte parser
// Per-byte frame state machine that yields at most one result per byte.
// ----------------------------------------------------------------------------
module gfc_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic [7:0]                      rx_byte_i,
  input  wire logic [gfc_pkg::MaxWidth-1:0]    nmea_max_i,
  output gfc_pkg::result_t                     result_o,
  output logic                                 result_valid_o
);

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_HEAD = 2'd2,
    MODE_BODY = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  prev_q, prev_d;
  logic [16:0] hpc_q, hpc_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  cls_q, cls_d;
  logic [7:0]  id_q, id_d;
  logic [16:0] bc_q, bc_d;

  logic [16:0] bc_inc;
  logic [16:0] hpc_inc;
  logic [16:0] len_plus;
  logic        emit;
  gfc_pkg::kind_e bin_kind;

  assign bc_inc   = bc_q + 17'd1;
  assign hpc_inc  = hpc_q + 17'd1;
  assign len_plus = {1'b0, len_q} + 17'd1;

  always_comb begin
    if (cls_q == 8'd0) begin
      bin_kind = gfc_pkg::KIND_NMEA;
    end else if (cls_q == gfc_pkg::ClassAck) begin
      bin_kind = (id_q == gfc_pkg::IdAck) ? gfc_pkg::KIND_ACK : gfc_pkg::KIND_NAK;
    end else if (cls_q == gfc_pkg::ClassTp) begin
      bin_kind = gfc_pkg::KIND_TP;
    end else begin
      bin_kind = gfc_pkg::KIND_UNKNOWN;
    end
  end

  always_comb begin
    mode_d = mode_q;
    prev_d = prev_q;
    hpc_d  = hpc_q;
    len_d  = len_q;
    cls_d  = cls_q;
    id_d   = id_q;
    bc_d   = bc_q;
    emit   = 1'b0;
    result_o.kind        = gfc_pkg::KIND_NMEA;
    result_o.msg_class   = 8'd0;
    result_o.msg_id      = 8'd0;
    result_o.payload_len = 16'd0;
    result_o.frame_bytes = bc_inc;
    if (step_i) begin
      prev_d = rx_byte_i;
      bc_d   = bc_inc;
      case (mode_q)
        MODE_HUNT: begin
          if (rx_byte_i == gfc_pkg::StartText) begin
            cls_d  = 8'd0;
            id_d   = 8'd0;
            len_d  = 16'd0;
            mode_d = MODE_TEXT;
          end else if (rx_byte_i == gfc_pkg::StartBin) begin
            hpc_d  = 17'd0;
            cls_d  = 8'd0;
            id_d   = 8'd0;
            len_d  = 16'd0;
            mode_d = MODE_HEAD;
          end else begin
            prev_d = 8'd0;
            hpc_d  = 17'd0;
            bc_d   = 17'd0;
          end
        end
        MODE_TEXT: begin
          if (bc_inc > {7'd0, nmea_max_i}) begin
            emit          = 1'b1;
            result_o.kind = gfc_pkg::KIND_TOO_LONG;
          end else if (prev_q == gfc_pkg::ChCr && rx_byte_i == gfc_pkg::ChLf) begin
            emit          = 1'b1;
            result_o.kind = gfc_pkg::KIND_NMEA;
          end
        end
        MODE_HEAD: begin
          if (hpc_q == 17'd0 && rx_byte_i != gfc_pkg::SyncTwo) begin
            emit          = 1'b1;
            result_o.kind = gfc_pkg::KIND_BAD_SYNC;
          end else begin
            if (hpc_q == 17'd1) begin
              cls_d = rx_byte_i;
            end else if (hpc_q == 17'd2) begin
              id_d = rx_byte_i;
            end else if (hpc_q == 17'd3) begin
              len_d = {8'd0, rx_byte_i};
            end else if (hpc_q != 17'd0) begin
              len_d = {rx_byte_i, len_q[7:0]};
            end
            if (hpc_inc >= 17'd5) begin
              hpc_d  = 17'd0;
              mode_d = MODE_BODY;
            end else begin
              hpc_d = hpc_inc;
            end
          end
        end
        default: begin
          if (hpc_q >= len_plus) begin
            emit                 = 1'b1;
            result_o.kind        = bin_kind;
            result_o.msg_class   = cls_q;
            result_o.msg_id      = id_q;
            result_o.payload_len = len_q;
          end else begin
            hpc_d = hpc_inc;
          end
        end
      endcase
      if (emit) begin
        mode_d = MODE_HUNT;
        prev_d = 8'd0;
        hpc_d  = 17'd0;
        bc_d   = 17'd0;
      end
    end
  end

  assign result_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      prev_q <= 8'd0;
      hpc_q  <= 17'd0;
      len_q  <= 16'd0;
      cls_q  <= 8'd0;
      id_q   <= 8'd0;
      bc_q   <= 17'd0;
    end else begin
      mode_q <= mode_d;
      prev_q <= prev_d;
      hpc_q  <= hpc_d;
      len_q  <= len_d;
      cls_q  <= cls_d;
      id_q   <= id_d;
      bc_q   <= bc_d;
    end
  end

endmodule
`default_nettype wire

>>> src/gnss_frame_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GNSS frame classifier
// Classifies text sentences and binary frames from a GNSS receiver byte link.
// ----------------------------------------------------------------------------
// Bytes arrive on the input channel (in_valid_i, in_stall_o, rx_byte_i); one
// word is taken at each clock edge where valid is high and stall is low.
// Each completed or failed frame yields one word on the output channel
// (out_valid_o, out_stall_i and the result fields).
// A result appears on the outputs in the cycle after the byte that ends the
// frame is taken. One byte is taken in every unstalled cycle with valid high;
// the per-byte state update is a single registered step in the parser.
// A result waits in the output register while the receiver stalls; the input
// stalls only while that register is full and the receiver is stalling, so a
// new byte is taken in the same cycle as a pending result leaves.
// Reset returns the parser to hunting for a frame start, empties the output
// register and sets the sentence length limit to 500 bytes. The user writes
// the limit at APB port address 0 only while idle; the block does not check.
// ----------------------------------------------------------------------------
module gnss_frame_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       result_kind_o,
  output logic [7:0]       message_class_o,
  output logic [7:0]       message_id_o,
  output logic [15:0]      payload_length_o,
  output logic [16:0]      frame_bytes_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [gfc_pkg::MaxWidth-1:0] nmea_max_q;
  logic                         out_valid_q;
  gfc_pkg::result_t             out_res_q;
  gfc_pkg::result_t             res;
  logic                         res_valid;
  logic                         step;
  logic                         sel_max;

  assign pready  = 1'b1;
  assign sel_max = ({paddr[2], 2'b00} == gfc_pkg::RegNmeaMax);
  assign prdata  = sel_max ? {22'd0, nmea_max_q} : 32'd0;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  gfc_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .rx_byte_i      (rx_byte_i),
    .nmea_max_i     (nmea_max_q),
    .result_o       (res),
    .result_valid_o (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nmea_max_q <= gfc_pkg::MaxDefault;
    end else if (psel && penable && pwrite && sel_max) begin
      nmea_max_q <= pwdata[gfc_pkg::MaxWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_res_q.kind;
  assign message_class_o  = out_res_q.msg_class;
  assign message_id_o     = out_res_q.msg_id;
  assign payload_length_o = out_res_q.payload_len;
  assign frame_bytes_o    = out_res_q.frame_bytes;

endmodule
`default_nettype wire
